@@ src/lsh_pkg.sv @@
// Shared types and constants of the Laplacian sharpen block.
package lsh_pkg;

  localparam int SAMPLE_W = 8;
  localparam int DIM_W    = 12;
  localparam int CHREG_W  = 3;
  localparam int ROW_W    = 11;
  localparam int SUM_W    = 12;
  localparam int CFG_IDX_W = 2;

  localparam int MIN_WIDTH    = 3;
  localparam int MIN_HEIGHT   = 3;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MIN_CHANNELS = 1;
  localparam int CENTRE_GAIN  = 5;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [DIM_W-1:0]   RESET_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0]   RESET_HEIGHT   = 12'd480;
  localparam logic [CHREG_W-1:0] RESET_CHANNELS = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  typedef struct packed {
    logic drain;
    logic produce;
    logic border;
    logic last;
  } lsh_cmd_t;

  localparam int CMD_W = $bits(lsh_cmd_t);

endpackage

@@ src/lsh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ src/lsh_queue.sv @@
// Short register queue between the front and back parts.
module lsh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != QCW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ src/lsh_front.sv @@
// Front part: configuration registers, raster counters and item classification.
module lsh_front
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [SAMPLE_W-1:0]                           s_tdata,
  input  logic                                          s_tuser,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]                          cfg_index,
  input  logic [DIM_W-1:0]                              cfg_data,
  input  logic                                          push_ready,
  output logic                                          push_valid,
  output lsh_cmd_t                                      push_cmd,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0]     push_addr,
  output logic [SAMPLE_W-1:0]                           push_sample,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]             chans
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int PW = $clog2(LINE_DEPTH + 1);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_CHANNELS + 1);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [CHREG_W-1:0] channel_count;
  logic [ROW_W-1:0]   row_pos;
  logic [PW-1:0]      samp_pos;
  logic [PW-1:0]      drain_pos;
  logic               frame_full;

  logic [WW-1:0]    w_eff;
  logic [CW-1:0]    ch_eff;
  logic [DIM_W-1:0] h_eff;
  logic [ROW_W-1:0] row_end;
  logic [PW-1:0]    row_len;
  logic [PW-1:0]    p_cur;
  logic [PW-1:0]    p_inc;
  logic [PW-1:0]    d_cur;
  logic             accept;
  logic             is_drain;
  logic             d_last;

  always_comb begin
    if (32'(image_width) < MIN_WIDTH) begin
      w_eff = WW'(MIN_WIDTH);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (32'(channel_count) < MIN_CHANNELS) begin
      ch_eff = CW'(MIN_CHANNELS);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      ch_eff = CW'(MAX_CHANNELS);
    end else begin
      ch_eff = CW'(channel_count);
    end
    if (32'(image_height) < MIN_HEIGHT) begin
      h_eff = DIM_W'(MIN_HEIGHT);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign row_len  = PW'(w_eff) * PW'(ch_eff);
  assign row_end  = ROW_W'(h_eff - 1'b1);
  assign p_cur    = (samp_pos >= row_len) ? '0 : samp_pos;
  assign p_inc    = p_cur + 1'b1;
  assign d_cur    = (drain_pos >= row_len) ? row_len - 1'b1 : drain_pos;
  assign d_last   = (d_cur == row_len - 1'b1);
  assign is_drain = (s_tuser == MODE_DRAIN);

  assign s_tready  = push_ready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign chans     = ch_eff;

  assign push_valid  = accept && (is_drain == frame_full);
  assign push_addr   = p_cur[AW-1:0];
  assign push_sample = s_tdata;

  always_comb begin
    push_cmd.drain   = is_drain;
    push_cmd.produce = is_drain || (row_pos != '0);
    push_cmd.border  = is_drain || (row_pos == ROW_W'(1)) || (p_cur < PW'(ch_eff))
                       || (p_cur >= row_len - PW'(ch_eff));
    push_cmd.last    = is_drain && d_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_WIDTH;
      image_height  <= RESET_HEIGHT;
      channel_count <= RESET_CHANNELS;
      row_pos       <= '0;
      samp_pos      <= '0;
      drain_pos     <= '0;
      frame_full    <= 1'b0;
    end else begin
      if (push_valid) begin
        if (is_drain) begin
          if (d_last) begin
            row_pos    <= '0;
            samp_pos   <= '0;
            drain_pos  <= '0;
            frame_full <= 1'b0;
          end else begin
            drain_pos <= d_cur + 1'b1;
          end
        end else if (p_inc >= row_len) begin
          samp_pos <= '0;
          if (row_pos >= row_end) begin
            frame_full <= 1'b1;
            drain_pos  <= '0;
          end else begin
            row_pos <= row_pos + 1'b1;
          end
        end else begin
          samp_pos <= p_inc;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH: begin
            image_width <= cfg_data;
          end
          REG_HEIGHT: begin
            image_height <= cfg_data;
          end
          REG_CHANNELS: begin
            channel_count <= cfg_data[CHREG_W-1:0];
          end
          default: begin
          end
        endcase
        if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
            || cfg_index == REG_CHANNELS) begin
          row_pos    <= '0;
          samp_pos   <= '0;
          drain_pos  <= '0;
          frame_full <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_full_on_last_row: assert property (@(posedge clk) disable iff (rst)
    frame_full |-> row_pos == row_end)
    else $error("frame marked full away from the last row");

  a_pos_in_row: assert property (@(posedge clk) disable iff (rst)
    samp_pos < row_len)
    else $error("sample position outside the row");
`endif

endmodule

@@ src/lsh_back.sv @@
// Back part: line stores, kernel arithmetic and output register.
module lsh_back
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  output logic                                      q_ready,
  input  lsh_cmd_t                                  q_cmd,
  input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] q_addr,
  input  logic [SAMPLE_W-1:0]                       q_sample,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]         chans,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [SAMPLE_W-1:0]                       m_tdata,
  output logic                                      m_tlast
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int HW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                advance;
  logic                pop;
  logic                b_valid;
  lsh_cmd_t            b_cmd;
  logic [AW-1:0]       b_addr;
  logic [SAMPLE_W-1:0] b_sample;
  logic [SAMPLE_W-1:0] hist [MAX_CHANNELS];
  logic [SAMPLE_W-1:0] mid_c;
  logic [SAMPLE_W-1:0] mid_r;
  logic [SAMPLE_W-1:0] up;
  logic [SAMPLE_W-1:0] left;
  logic [AW-1:0]       right_addr;
  logic [HW-1:0]       tap;
  logic [SUM_W-1:0]    acc;
  logic [SAMPLE_W-1:0] sat;
  logic                b_store;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_last;

  assign advance    = !out_valid || m_tready;
  assign q_ready    = advance;
  assign pop        = q_valid && advance;
  assign right_addr = q_addr + AW'(chans);
  assign b_store    = advance && b_valid && !b_cmd.drain;
  assign tap        = HW'(chans - 1'b1);
  assign left       = hist[tap];

  lsh_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_mid_centre (
    .clk   (clk),
    .we    (pop && !q_cmd.drain),
    .waddr (q_addr),
    .wdata (q_sample),
    .re    (pop),
    .raddr (q_addr),
    .rdata (mid_c)
  );

  lsh_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_mid_right (
    .clk   (clk),
    .we    (pop && !q_cmd.drain),
    .waddr (q_addr),
    .wdata (q_sample),
    .re    (pop),
    .raddr (right_addr),
    .rdata (mid_r)
  );

  lsh_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_upper (
    .clk   (clk),
    .we    (b_store),
    .waddr (b_addr),
    .wdata (mid_c),
    .re    (pop),
    .raddr (q_addr),
    .rdata (up)
  );

  always_comb begin
    acc = SUM_W'(CENTRE_GAIN) * SUM_W'(mid_c) - SUM_W'(left) - SUM_W'(mid_r)
          - SUM_W'(up) - SUM_W'(b_sample);
    if (acc[SUM_W-1]) begin
      sat = '0;
    end else if (acc[SUM_W-2:SAMPLE_W] != '0) begin
      sat = '1;
    end else begin
      sat = acc[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_cmd     <= q_cmd;
      b_addr    <= q_addr;
      b_sample  <= q_sample;
      out_value <= (b_cmd.drain || b_cmd.border) ? '0 : sat;
      out_last  <= b_cmd.drain && b_cmd.last;
    end
    if (b_store) begin
      hist[0] <= mid_c;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b_valid   <= pop;
      out_valid <= b_valid && (b_cmd.drain || b_cmd.produce);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tlast  = out_last;

`ifndef SYNTHESIS
  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_value == '0)
    else $error("frame end result not zero");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !advance |=> b_valid && $stable(b_addr))
    else $error("kernel stage lost its item while stalled");
`endif

endmodule

@@ src/laplacian_sharpen_3x3.sv @@
// Top level of the streaming 3x3 Laplacian sharpen block.
//
//   channel  direction  handshake               payload
//   s_*      in         s_tvalid / s_tready     s_tdata = sample, s_tuser = mode
//   m_*      out        m_tvalid / m_tready     m_tdata = value, m_tlast = frame_last
//   cfg_*    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle while m_tready is high; items pass queue, kernel and output registers.
// The rate is set by the single read of each line store per item, all at one address pair.
// A four-entry queue parts the counters from the line-store pipeline; the output register
// holds a result while m_tready is low and the queue fills behind it.
// Synchronous reset clears counters, config registers and handshakes, but not line stores or data.
module laplacian_sharpen_3x3
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [SAMPLE_W-1:0]  s_tdata,   // [7:0] sample
  input  logic                 s_tuser,   // [0] mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  m_tdata,   // [7:0] value
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_CHANNELS);
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int QW = CMD_W + AW + SAMPLE_W;

  logic                push_ready;
  logic                push_valid;
  lsh_cmd_t            push_cmd;
  logic [AW-1:0]       push_addr;
  logic [SAMPLE_W-1:0] push_sample;
  logic [CW-1:0]       chans;
  logic                q_valid;
  logic                q_ready;
  logic [QW-1:0]       q_data;
  lsh_cmd_t            q_cmd;
  logic [AW-1:0]       q_addr;
  logic [SAMPLE_W-1:0] q_sample;

  lsh_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_cmd    (push_cmd),
    .push_addr   (push_addr),
    .push_sample (push_sample),
    .chans       (chans)
  );

  lsh_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   ({push_cmd, push_addr, push_sample}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign {q_cmd, q_addr, q_sample} = q_data;

  lsh_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .q_addr   (q_addr),
    .q_sample (q_sample),
    .chans    (chans),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

@@ sim/laplacian_sharpen_checker.sv @@
// Checker for the Laplacian sharpen block: predicts each result and compares it on the output.
module laplacian_sharpen_checker
  import lsh_pkg::*;
#(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [SAMPLE_W-1:0]  s_tdata,   // [7:0] sample
  input  logic                 s_tuser,   // [0] mode
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [SAMPLE_W-1:0]  m_tdata,   // [7:0] value
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding,
  output int                   results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
  localparam int REPORT_LIMIT = 10;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_last;
  } sharpened_t;

  sharpened_t          expected_pixels[$];
  logic [SAMPLE_W-1:0] upper_row [LINE_DEPTH];
  logic [SAMPLE_W-1:0] middle_row[LINE_DEPTH];
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  logic [CHREG_W-1:0]  chan_reg;
  int unsigned         row_idx;
  int unsigned         col_idx;
  int unsigned         drain_idx;
  bit                  frame_full;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    row_idx    = 0;
    col_idx    = 0;
    drain_idx  = 0;
    frame_full = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    case (idx)
      REG_WIDTH:    width_reg  = data;
      REG_HEIGHT:   height_reg = data;
      REG_CHANNELS: chan_reg   = data[CHREG_W-1:0];
      default:      return;
    endcase
    restart_frame();
  endtask

  task automatic sharpen_item(input logic mode, input logic [SAMPLE_W-1:0] smp);
    int unsigned ch;
    int unsigned row_len;
    int unsigned p;
    int          acc;
    sharpened_t  px;
    ch      = clamp_dim(chan_reg, MIN_CHANNELS, MAX_CHANNELS);
    row_len = clamp_dim(width_reg, MIN_WIDTH, MAX_WIDTH) * ch;
    if (mode == MODE_DRAIN) begin
      if (!frame_full) return;
      if (drain_idx >= row_len) drain_idx = row_len - 1;
      px.value      = '0;
      px.frame_last = (drain_idx == row_len - 1);
      expected_pixels.push_back(px);
      if (px.frame_last) restart_frame();
      else drain_idx++;
      return;
    end
    if (frame_full) return;
    if (col_idx >= row_len) col_idx = 0;
    p = col_idx;
    if (row_idx >= 1) begin
      px = '0;
      if (row_idx > 1 && p >= ch && p < row_len - ch) begin
        acc = CENTRE_GAIN * int'(middle_row[p]) - int'(upper_row[p - ch])
              - int'(middle_row[p + ch]) - int'(upper_row[p]) - int'(smp);
        if (acc < 0) acc = 0;
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        px.value = acc[SAMPLE_W-1:0];
      end
      expected_pixels.push_back(px);
    end
    upper_row[p]  = middle_row[p];
    middle_row[p] = smp;
    p++;
    if (p >= row_len) begin
      p = 0;
      if (row_idx >= clamp_dim(height_reg, MIN_HEIGHT, MAX_HEIGHT) - 1) begin
        frame_full = 1'b1;
        drain_idx  = 0;
      end else begin
        row_idx++;
      end
    end
    col_idx = p;
  endtask

  task automatic check_result(input logic [SAMPLE_W-1:0] value, input logic last);
    sharpened_t want;
    results_checked++;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: result value %0d last %0b arrived with nothing expected",
                 $time, value, last);
    end else begin
      want = expected_pixels.pop_front();
      if (value !== want.value || last !== want.frame_last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: expected value %0d last %0b, got value %0d last %0b",
                   $time, want.value, want.frame_last, value, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      chan_reg   = RESET_CHANNELS;
      restart_frame();
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sharpen_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
    end
    outstanding = expected_pixels.size();
  end

endmodule

@@ sim/laplacian_sharpen_3x3_tb.sv @@
// Testbench top for the Laplacian sharpen block: stimulus, stalls and the verdict.
module laplacian_sharpen_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsh_pkg::*;

  localparam int LINE_WIDTH_MAX = 2048;
  localparam int CHANNELS_MAX   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 850;
  localparam int STALL_PERCENT  = 15;
  localparam int WIDE_ITEMS     = 150;
  localparam int TALL_ITEMS     = 60;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [SAMPLE_W-1:0] PEAK_FRAME[9] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
  localparam logic [SAMPLE_W-1:0] RAMP_FRAME[9] = '{0, 50, 0, 60, 100, 70, 0, 80, 0};

  typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_BINARY} sample_style_e;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [SAMPLE_W-1:0]  s_tdata;   // [7:0] sample
  logic                 s_tuser;   // [0] mode
  logic                 m_tvalid;
  logic                 m_tready;
  logic [SAMPLE_W-1:0]  m_tdata;   // [7:0] value
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int fail_count;
  int outstanding;
  int results_checked;

  int                 stall_percent;
  int unsigned        items_sent;
  int unsigned        random_items;
  int unsigned        cfg_writes;
  int unsigned        frames_done;
  logic [DIM_W-1:0]   cur_width;
  logic [DIM_W-1:0]   cur_height;
  logic [CHREG_W-1:0] cur_chan;

  laplacian_sharpen_3x3 #(
    .MAX_WIDTH   (LINE_WIDTH_MAX),
    .MAX_CHANNELS(CHANNELS_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  laplacian_sharpen_checker #(
    .MAX_WIDTH   (LINE_WIDTH_MAX),
    .MAX_CHANNELS(CHANNELS_MAX)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= stall_percent);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(sample_style_e style,
                                                      logic [SAMPLE_W-1:0] base);
    int v;
    case (style)
      STYLE_SMOOTH: begin
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      STYLE_BINARY: v = $urandom_range(1) ? 255 : 0;
      default:      v = $urandom_range(255);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] smp, input bit counted);
    @(negedge clk);
    while ($urandom_range(99) < stall_percent) begin
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = smp;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (counted) random_items++;
  endtask

  // hold the sender until every expected result has left the block
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_WIDTH:    cur_width  = data;
      REG_HEIGHT:   cur_height = data;
      REG_CHANNELS: cur_chan   = data[CHREG_W-1:0];
      default:      ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [DIM_W-1:0] c);
    settle();
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    set_reg(REG_CHANNELS, c);
  endtask

  task automatic pick_config();
    bit          wrote;
    int unsigned cv;
    wrote = 1'b0;
    if ($urandom_range(19) == 0) set_reg(REG_UNUSED, 12'($urandom));
    if ($urandom_range(2) != 0) begin
      set_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                  : 12'($urandom_range(3, 10)));
      wrote = 1'b1;
    end
    if ($urandom_range(2) != 0) begin
      set_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                   : 12'($urandom_range(3, 6)));
      wrote = 1'b1;
    end
    if (!wrote || $urandom_range(2) != 0) begin
      if ($urandom_range(7) == 0) begin
        cv = $urandom_range(3);
        if (cv != 0) cv = cv + 4;
      end else begin
        cv = $urandom_range(1, 4);
      end
      set_reg(REG_CHANNELS, {9'($urandom), 3'(cv)});
    end
  endtask

  task automatic run_frame(input sample_style_e style, input bit noisy, input bit may_abandon,
                           input bit counted, output bit finished);
    int unsigned         row_len;
    int unsigned         total;
    int unsigned         cut;
    int unsigned         k;
    logic [SAMPLE_W-1:0] base;
    row_len  = clamp_to(cur_width, MIN_WIDTH, LINE_WIDTH_MAX)
               * clamp_to(cur_chan, MIN_CHANNELS, CHANNELS_MAX);
    total    = row_len * clamp_to(cur_height, MIN_HEIGHT, MAX_HEIGHT);
    cut      = may_abandon ? $urandom_range(total - 1) : total;
    base     = $urandom;
    finished = 1'b0;
    for (k = 0; k < total; k++) begin
      if (k == cut) return;
      if (noisy && $urandom_range(15) == 0) send_item(MODE_DRAIN, 8'($urandom), 1'b0);
      if (counted && $urandom_range(299) == 0) settle();
      send_item(MODE_SAMPLE, pick_sample(style, base), counted);
    end
    if (noisy) repeat ($urandom_range(1, 3)) send_item(MODE_SAMPLE, 8'($urandom), 1'b0);
    for (k = 0; k < row_len; k++) send_item(MODE_DRAIN, 8'($urandom), counted);
    if (noisy) send_item(MODE_DRAIN, 8'($urandom), 1'b0);
    finished = 1'b1;
    frames_done++;
  endtask

  initial begin
    bit          finished;
    int unsigned k;
    int unsigned nframes;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = MODE_SAMPLE;
    cfg_valid     = 1'b0;
    cfg_index     = REG_WIDTH;
    cfg_data      = '0;
    cur_width     = RESET_WIDTH;
    cur_height    = RESET_HEIGHT;
    cur_chan      = RESET_CHANNELS;
    stall_percent = STALL_PERCENT;
    items_sent    = 0;
    random_items  = 0;
    cfg_writes    = 0;
    frames_done   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default geometry: first row gives nothing
    repeat (2) send_item(MODE_SAMPLE, 8'($urandom), 1'b0);

    set_geometry(12'd3, 12'd3, {9'($urandom), 3'd1});
    send_item(MODE_DRAIN, 8'hFF, 1'b0);
    foreach (PEAK_FRAME[k]) send_item(MODE_SAMPLE, PEAK_FRAME[k], 1'b0);
    send_item(MODE_SAMPLE, 8'hFF, 1'b0);
    repeat (3) send_item(MODE_DRAIN, 8'h00, 1'b0);
    foreach (RAMP_FRAME[k]) begin
      if (k == 6) settle();
      send_item(MODE_SAMPLE, RAMP_FRAME[k], 1'b0);
    end
    repeat (3) send_item(MODE_DRAIN, 8'h00, 1'b0);
    frames_done += 2;

    // clamped and extreme geometries; the widest and tallest frames are dropped part way
    set_geometry(12'd0, 12'd2, 12'd7);
    run_frame(STYLE_BINARY, 1'b1, 1'b0, 1'b0, finished);
    set_geometry(12'hFFF, 12'd3, 12'd4);
    repeat (WIDE_ITEMS) send_item(MODE_SAMPLE, 8'($urandom), 1'b0);
    set_geometry(12'd3, 12'hFFF, 12'hFF8);
    repeat (TALL_ITEMS) send_item(MODE_SAMPLE, 8'($urandom), 1'b0);
    set_geometry(12'd40, 12'd3, 12'd2);
    stall_percent = 0;
    run_frame(STYLE_SMOOTH, 1'b0, 1'b0, 1'b0, finished);
    stall_percent = STALL_PERCENT;

    while (random_items < RANDOM_ITEMS) begin
      settle();
      pick_config();
      stall_percent = ($urandom_range(5) == 0) ? 0 : STALL_PERCENT;
      nframes = $urandom_range(1, 3);
      for (k = 0; k < nframes; k++) begin
        run_frame(sample_style_e'($urandom_range(2)), $urandom_range(3) == 0,
                  $urandom_range(7) == 0, 1'b1, finished);
        if (!finished) break;
      end
    end
    stall_percent = STALL_PERCENT;
    settle();

    $display("Run covered %0d input transactions (%0d in random frames), %0d register writes",
             items_sent, random_items, cfg_writes);
    $display("and %0d whole frames; %0d results checked, %0d mismatches",
             frames_done, results_checked, fail_count);
    if (fail_count == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
src/lsh_pkg.sv
src/lsh_ram.sv
src/lsh_queue.sv
src/lsh_front.sv
src/lsh_back.sv
src/laplacian_sharpen_3x3.sv
sim/laplacian_sharpen_checker.sv
sim/laplacian_sharpen_3x3_tb.sv
